/* rtl/core/window_median_filter_defines.svh */
// assertion macros for the window median filter
`ifndef WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define WINDOW_MEDIAN_FILTER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define WMF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("window_median_filter: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define WMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("window_median_filter: next-cycle check failed");

`endif

/* rtl/core/wmf_pkg.sv */
package wmf_pkg;

  // per-cell control, driven by the top level each cycle
  typedef struct packed {
    logic load;      // a sample transaction is taken this cycle
    logic occupied;  // cell holds a sample of the current window
    logic at_end;    // cell is the first free slot of the window
  } wmf_cell_ctrl_t;

endpackage

/* rtl/core/wmf_cell.sv */
module wmf_cell #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                       clk_i,
  input  wmf_pkg::wmf_cell_ctrl_t    ctrl_i,
  input  logic [SAMPLE_BITS-1:0]     sample_i,
  input  logic [SAMPLE_BITS-1:0]     prev_value_i,
  input  logic                       prev_gt_i,
  output logic [SAMPLE_BITS-1:0]     value_o,
  output logic                       gt_o,
  output logic [SAMPLE_BITS-1:0]     next_value_o
);

  logic [SAMPLE_BITS-1:0] value_q;
  logic [SAMPLE_BITS-1:0] value_d;
  logic                   write;

  // held entry is larger than the incoming sample
  assign gt_o = ctrl_i.occupied && (value_q > sample_i);

  // shift up from the neighbor, or take the sample in the freed slot
  assign value_d = prev_gt_i ? prev_value_i : sample_i;
  assign write   = ctrl_i.load && (gt_o || ctrl_i.at_end);

  always_ff @(posedge clk_i) begin
    if (write) begin
      value_q <= value_d;
    end
  end

  assign value_o      = value_q;
  assign next_value_o = write ? value_d : value_q;

endmodule

/* rtl/core/window_median_filter.sv */
// window_median_filter
//
// Collects raw converter samples into non-overlapping windows of WINDOW_COUNT
// samples and returns one median per window: the element at sorted index
// WINDOW_COUNT/2 (the upper median for an even count).
//
// input channel: sample_i with sample_valid_i / sample_stall_o. A transaction
// is taken at a clock edge where valid is high and stall is low.
// output channel: median_o with median_valid_o / median_stall_i.
//
// Throughput: one sample per cycle while sample_stall_o is low. Each sample
// goes into a row of compare-and-shift cells; every cell compares against the
// new sample in parallel and moves one place up. Output: the median shows on
// median_o in the cycle after the transaction that completes the window. The
// median sits in an output register; while it waits under median_stall_i,
// samples keep flowing in, and sample_stall_o rises only if the next sample
// would complete another window.
// Reset: the window count returns to zero, no median pending. The cell
// contents are not cleared; only entries written in the current window are
// ever compared or read.
`include "window_median_filter_defines.svh"

module window_median_filter #(
  parameter int unsigned WINDOW_COUNT = 20,
  parameter int unsigned SAMPLE_BITS  = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sample_valid_i,
  output logic                   sample_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   median_valid_o,
  input  logic                   median_stall_i,
  output logic [SAMPLE_BITS-1:0] median_o
);

  // fill counter holds 0 .. WINDOW_COUNT-1
  localparam int unsigned CNT_W = $clog2(WINDOW_COUNT + 1);
  localparam int unsigned MID   = WINDOW_COUNT / 2;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WINDOW_COUNT - 1);

  logic [CNT_W-1:0]       fill_q, fill_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0] median_q;

  logic                   in_acc;
  logic                   out_acc;
  logic                   win_done;

  // chain links between neighbor cells
  logic [SAMPLE_BITS-1:0] cell_value [WINDOW_COUNT];
  logic [SAMPLE_BITS-1:0] cell_next  [WINDOW_COUNT];
  logic                   cell_gt    [WINDOW_COUNT];
  wmf_pkg::wmf_cell_ctrl_t cell_ctrl [WINDOW_COUNT];

  // handshakes: stall only when a waiting median would be overwritten
  assign sample_stall_o = out_valid_q && median_stall_i && (fill_q == LAST);
  assign in_acc         = sample_valid_i && !sample_stall_o;
  assign out_acc        = out_valid_q && !median_stall_i;
  assign win_done       = in_acc && (fill_q == LAST);

  // row of insertion cells, cell 0 holds the smallest value
  for (genvar i = 0; i < WINDOW_COUNT; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] prev_value;
    logic                   prev_gt;

    if (i == 0) begin : g_head
      assign prev_value = sample_i;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    assign cell_ctrl[i].load     = in_acc;
    assign cell_ctrl[i].occupied = fill_q > CNT_W'(i);
    assign cell_ctrl[i].at_end   = fill_q == CNT_W'(i);

    wmf_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl[i]),
      .sample_i    (sample_i),
      .prev_value_i(prev_value),
      .prev_gt_i   (prev_gt),
      .value_o     (cell_value[i]),
      .gt_o        (cell_gt[i]),
      .next_value_o(cell_next[i])
    );
  end

  // window counter and output register control
  always_comb begin
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      fill_d = win_done ? '0 : fill_q + CNT_W'(1);
    end
    if (win_done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // median taken from the middle cell's updated value
  always_ff @(posedge clk_i) begin
    if (win_done) begin
      median_q <= cell_next[MID];
    end
  end

  assign median_valid_o = out_valid_q;
  assign median_o       = median_q;

  // checks
  `WMF_ASSERT_IMPL(a_fill_range, 1'b1, fill_q <= LAST)
  `WMF_ASSERT_NEXT(a_win_restart, win_done, fill_q == '0 && out_valid_q)
  `WMF_ASSERT_NEXT(a_median_cause, !out_valid_q && !win_done, !out_valid_q)

  for (genvar k = 1; k < WINDOW_COUNT; k++) begin : g_chk
    `WMF_ASSERT_IMPL(a_sorted, fill_q > CNT_W'(k), cell_value[k-1] <= cell_value[k])
  end

endmodule
